>>> design/swwl_pkg.sv
// Shared types and constants for the stop-and-wait word link.
// Holds op codes, command classes, the command and result records and FIFO defaults.
// No dependencies.
`timescale 1ns / 1ps

package swwl_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 16;
  localparam int unsigned PAIR_LEN       = 2;
  localparam logic [7:0]  ACK_BYTE       = 8'hC0;

  // host-side op codes as they arrive on op_i
  typedef enum logic [2:0] {
    OP_QUEUE  = 3'd0,
    OP_LINE   = 3'd1,
    OP_UPDATE = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  // command class after decode; unused op codes become CMD_NOP
  typedef enum logic [2:0] {
    CMD_QUEUE,
    CMD_LINE,
    CMD_UPDATE,
    CMD_READ,
    CMD_CLEAR,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [15:0] word;
    logic [7:0]  line_byte;
    logic        is_ack;
  } cmd_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        may_proceed;
    logic [15:0] read_word;
    logic        word_available;
    logic        overflow;
    logic        last;
  } res_t;

  // handshake between front queue and back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_QLO,
    BK_TXRD0,
    BK_TXRD1,
    BK_RXRD0,
    BK_RXRD1
  } back_state_e;

endpackage

>>> design/swwl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for both byte FIFOs of the link. No dependencies.
`timescale 1ns / 1ps

module swwl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/swwl_front.sv
// Front end: accepts input items, classifies the op and holds them in a two-slot queue.
// Depends on swwl_pkg.
`timescale 1ns / 1ps

module swwl_front
  import swwl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [15:0] host_word_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        cmd_pop_i,
  output cmd_req_t    cmd_req_o
);

  logic v0_q, v0_d, v1_q, v1_d;
  cmd_t s0_q, s0_d, s1_q, s1_d;
  cmd_t new_cmd;
  logic push;

  always_comb begin
    new_cmd.word      = host_word_i;
    new_cmd.line_byte = rx_byte_i;
    new_cmd.is_ack    = (rx_byte_i == ACK_BYTE);
    unique case (op_i)
      OP_QUEUE:  new_cmd.kind = CMD_QUEUE;
      OP_LINE:   new_cmd.kind = CMD_LINE;
      OP_UPDATE: new_cmd.kind = CMD_UPDATE;
      OP_READ:   new_cmd.kind = CMD_READ;
      OP_CLEAR:  new_cmd.kind = CMD_CLEAR;
      default:   new_cmd.kind = CMD_NOP;
    endcase
  end

  assign in_stall_o = v1_q;
  assign push       = in_valid_i && !v1_q;

  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    s0_d = s0_q;
    s1_d = s1_q;
    if (cmd_pop_i) begin
      v0_d = v1_q;
      s0_d = s1_q;
      v1_d = 1'b0;
    end
    if (push) begin
      if (!v0_d) begin
        v0_d = 1'b1;
        s0_d = new_cmd;
      end else begin
        v1_d = 1'b1;
        s1_d = new_cmd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  assign cmd_req_o.valid = v0_q;
  assign cmd_req_o.cmd   = s0_q;

endmodule

>>> design/swwl_back.sv
// Back end: runs commands against the transmit and receive byte FIFOs and the ack state,
// and drives the result register. Depends on swwl_pkg and swwl_ram.
`timescale 1ns / 1ps

module swwl_back
  import swwl_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cmd_req_t cmd_req_i,
  output logic     cmd_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output res_t     res_o
);

  localparam int unsigned IW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(FIFO_DEPTH);
  localparam logic [CW-1:0] CNT_PAIR = CW'(PAIR_LEN);

  // (a + b) mod depth, valid while a + b < 2 * depth
  function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = {{(CW + 1 - IW){1'b0}}, a} + {1'b0, b};
    if (s >= (CW + 1)'(FIFO_DEPTH)) begin
      s = s - (CW + 1)'(FIFO_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  back_state_e state_q, state_d;
  logic [CW-1:0] tx_count_q, tx_count_d, rx_count_q, rx_count_d;
  logic [IW-1:0] tx_head_q, tx_head_d, rx_head_q, rx_head_d;
  logic acked_q, acked_d, exp_first_q, exp_first_d;
  logic ovf_q, ovf_d;
  logic [7:0] hi_q, hi_d;
  logic out_valid_q, out_valid_d;
  res_t res_q, res_d;
  logic out_free, emit;

  logic          tx_we, tx_re, rx_we, rx_re;
  logic [IW-1:0] tx_waddr, tx_raddr, rx_waddr, rx_raddr;
  logic [7:0]    tx_wdata, tx_rdata, rx_wdata, rx_rdata;
  logic [15:0]   rd_word;
  logic          tx_full, rx_full;

  swwl_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (tx_wdata),
    .re_i    (tx_re),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  swwl_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (rx_wdata),
    .re_i    (rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign tx_full  = (tx_count_q == CNT_FULL);
  assign rx_full  = (rx_count_q == CNT_FULL);
  assign tx_waddr = wrap_add(tx_head_q, tx_count_q);
  assign rx_waddr = wrap_add(rx_head_q, rx_count_q);
  assign rd_word  = {hi_q, rx_rdata};

  always_comb begin
    state_d     = state_q;
    tx_count_d  = tx_count_q;
    rx_count_d  = rx_count_q;
    tx_head_d   = tx_head_q;
    rx_head_d   = rx_head_q;
    acked_d     = acked_q;
    exp_first_d = exp_first_q;
    ovf_d       = ovf_q;
    hi_d        = hi_q;
    res_d       = '0;
    emit        = 1'b0;
    cmd_pop_o   = 1'b0;
    tx_we       = 1'b0;
    tx_wdata    = cmd_req_i.cmd.word[15:8];
    tx_re       = 1'b0;
    tx_raddr    = tx_head_q;
    rx_we       = 1'b0;
    rx_wdata    = cmd_req_i.cmd.line_byte;
    rx_re       = 1'b0;
    rx_raddr    = rx_head_q;

    unique case (state_q)
      BK_IDLE: begin
        if (cmd_req_i.valid) begin
          unique case (cmd_req_i.cmd.kind)
            CMD_QUEUE: begin
              // high byte now, low byte in the next step
              ovf_d = tx_full;
              if (!tx_full) begin
                tx_we      = 1'b1;
                tx_count_d = tx_count_q + 1'b1;
              end
              state_d = BK_QLO;
            end
            CMD_LINE: begin
              if (out_free) begin
                emit      = 1'b1;
                cmd_pop_o = 1'b1;
                if (exp_first_q && cmd_req_i.cmd.is_ack) begin
                  acked_d = 1'b1;
                end else begin
                  exp_first_d    = !exp_first_q;
                  res_d.overflow = rx_full;
                  if (!rx_full) begin
                    rx_we      = 1'b1;
                    rx_count_d = rx_count_q + 1'b1;
                  end
                  // ack goes out after the first byte of a pair
                  if (exp_first_q) begin
                    res_d.tx_valid = 1'b1;
                    res_d.tx_byte  = ACK_BYTE;
                  end
                end
              end
            end
            CMD_UPDATE: begin
              if (acked_q && tx_count_q >= CNT_PAIR) begin
                tx_re   = 1'b1;
                state_d = BK_TXRD0;
              end else if (out_free) begin
                emit              = 1'b1;
                cmd_pop_o         = 1'b1;
                res_d.may_proceed = acked_q;
              end
            end
            CMD_READ: begin
              if (rx_count_q >= CNT_PAIR) begin
                rx_re   = 1'b1;
                state_d = BK_RXRD0;
              end else if (out_free) begin
                emit      = 1'b1;
                cmd_pop_o = 1'b1;
              end
            end
            CMD_CLEAR: begin
              if (out_free) begin
                emit       = 1'b1;
                cmd_pop_o  = 1'b1;
                tx_count_d = '0;
                rx_count_d = '0;
                tx_head_d  = '0;
                rx_head_d  = '0;
              end
            end
            default: begin
              if (out_free) begin
                emit      = 1'b1;
                cmd_pop_o = 1'b1;
              end
            end
          endcase
        end
      end
      BK_QLO: begin
        if (out_free) begin
          tx_wdata       = cmd_req_i.cmd.word[7:0];
          emit           = 1'b1;
          cmd_pop_o      = 1'b1;
          res_d.overflow = ovf_q || tx_full;
          if (!tx_full) begin
            tx_we      = 1'b1;
            tx_count_d = tx_count_q + 1'b1;
          end
          state_d = BK_IDLE;
        end
      end
      BK_TXRD0: begin
        if (out_free) begin
          emit              = 1'b1;
          res_d.tx_valid    = 1'b1;
          res_d.tx_byte     = tx_rdata;
          res_d.may_proceed = 1'b1;
          tx_re             = 1'b1;
          tx_raddr          = wrap_add(tx_head_q, CW'(1));
          state_d           = BK_TXRD1;
        end
      end
      BK_TXRD1: begin
        if (out_free) begin
          emit              = 1'b1;
          cmd_pop_o         = 1'b1;
          res_d.tx_valid    = 1'b1;
          res_d.tx_byte     = tx_rdata;
          res_d.may_proceed = 1'b1;
          tx_head_d         = wrap_add(tx_head_q, CNT_PAIR);
          tx_count_d        = tx_count_q - CNT_PAIR;
          acked_d           = 1'b0;
          state_d           = BK_IDLE;
        end
      end
      BK_RXRD0: begin
        hi_d     = rx_rdata;
        rx_re    = 1'b1;
        rx_raddr = wrap_add(rx_head_q, CW'(1));
        state_d  = BK_RXRD1;
      end
      BK_RXRD1: begin
        if (out_free) begin
          emit            = 1'b1;
          cmd_pop_o       = 1'b1;
          res_d.read_word = (~^rd_word) ? rd_word : 16'h0000;
          rx_head_d       = wrap_add(rx_head_q, CNT_PAIR);
          rx_count_d      = rx_count_q - CNT_PAIR;
          state_d         = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    res_d.word_available = (rx_count_d >= CNT_PAIR);
    res_d.last           = cmd_pop_o;
    out_valid_d          = emit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      tx_count_q  <= '0;
      rx_count_q  <= '0;
      tx_head_q   <= '0;
      rx_head_q   <= '0;
      acked_q     <= 1'b1;
      exp_first_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tx_count_q  <= tx_count_d;
      rx_count_q  <= rx_count_d;
      tx_head_q   <= tx_head_d;
      rx_head_q   <= rx_head_d;
      acked_q     <= acked_d;
      exp_first_q <= exp_first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q <= ovf_d;
    hi_q  <= hi_d;
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

>>> design/stop_and_wait_word_link.sv
// Top level of the stop-and-wait word link: front queue plus back end.
// Depends on swwl_pkg, swwl_front, swwl_back (and swwl_ram below it).
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------------
//   in      | in_valid_i / in_stall_o | op_i, host_word_i, rx_byte_i
//   out     | out_valid_o / out_stall_i | tx_valid_o, tx_byte_o, may_proceed_o,
//           |                        | read_word_o, word_available_o, overflow_o, last_o
//
// Back end: line byte, clear, idle poll end in BK_IDLE; queue word adds BK_QLO (one RAM
// write port); sending update and read add TXRD0/1 and RXRD0/1 (two registered RAM reads).
// A two-slot command queue lets input transfers continue while results stall.
// Reset (async, active low) empties both FIFOs and the queue; RAM contents are not cleared.
// out_stall_i holds the result register and the back end; in_stall_o rises when the queue is full.
`timescale 1ns / 1ps

module stop_and_wait_word_link
  import swwl_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [15:0] host_word_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        may_proceed_o,
  output logic [15:0] read_word_o,
  output logic        word_available_o,
  output logic        overflow_o,
  output logic        last_o
);

  cmd_req_t cmd_req;
  logic     cmd_pop;
  res_t     res;

  swwl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .host_word_i (host_word_i),
    .rx_byte_i   (rx_byte_i),
    .cmd_pop_i   (cmd_pop),
    .cmd_req_o   (cmd_req)
  );

  swwl_back #(.FIFO_DEPTH(FIFO_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_req_i   (cmd_req),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign tx_valid_o       = res.tx_valid;
  assign tx_byte_o        = res.tx_byte;
  assign may_proceed_o    = res.may_proceed;
  assign read_word_o      = res.read_word;
  assign word_available_o = res.word_available;
  assign overflow_o       = res.overflow;
  assign last_o           = res.last;

  // the back end only retires a command that the queue holds
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> cmd_req.valid)
    else $error("command retired from an empty queue");

  // a full queue always presents its head
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> cmd_req.valid)
    else $error("input stalled with no pending command");

  // only the first byte of a sent pair is a non-final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (tx_valid_o && may_proceed_o))
    else $error("non-final result that is not a data byte");

  // line bytes outside an update are always the ack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tx_valid_o && !may_proceed_o) |-> (tx_byte_o == ACK_BYTE))
    else $error("unexpected line byte outside an update");

endmodule
